>>> src/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared types and constants for the feedback delay with soft clip.
// ----------------------------------------------------------------------------
package fdsc_pkg;

   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int SAMPLE_W        = 16;
   localparam int OUT_W           = 17;
   localparam int TARGET_W        = 12;
   localparam int FRAC_W          = 24;
   localparam int SMOOTH_W        = TARGET_W + FRAC_W;
   localparam int GLIDE_SHIFT     = 21;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd2400;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [OUT_W-1:0]    wide_sample_type;

endpackage

>>> src/fdsc_store.sv
// ----------------------------------------------------------------------------
// fdsc_store
// Delay line memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fdsc_store
   import fdsc_pkg::*;
#(
   parameter int DEPTH = DELAY_DEPTH_DEF,
   parameter int AW    = $clog2(DELAY_DEPTH_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  sample_type    wr_data,
   input  logic [AW-1:0] rd_addr,
   output sample_type    rd_data
);

   sample_type store_mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fdsc_soft_clip.sv
// ----------------------------------------------------------------------------
// fdsc_soft_clip
// Clamp to +-1.0 and cubic soft clip 1.5x - 0.5x^3, two register stages.
// ----------------------------------------------------------------------------
module fdsc_soft_clip
   import fdsc_pkg::*;
(
   input  logic            clock,
   input  wide_sample_type sum_in,
   output sample_type      clip_out
);

   localparam logic signed [OUT_W-1:0] POS_ONE = 17'sh08000;
   localparam logic signed [OUT_W-1:0] NEG_ONE = -17'sh08000;

   logic signed [OUT_W-1:0]      c_in, c_ff, c2_ff;
   logic signed [2*OUT_W-1:0]    sq_full;
   logic signed [31:0]           sq_in, sq_ff;
   logic signed [48:0]           cube_in, cube_ff;
   logic signed [OUT_W+1:0]      c3;
   logic signed [48:0]           num;
   logic signed [17:0]           y_w;

   always_comb begin
      if (sum_in > POS_ONE) begin
         c_in = POS_ONE;
      end else if (sum_in < NEG_ONE) begin
         c_in = NEG_ONE;
      end else begin
         c_in = sum_in;
      end
      sq_full = c_in * c_in;
      sq_in   = sq_full[31:0];
      cube_in = sq_ff * c2_ff;
   end

   always_ff @(posedge clock) begin
      c2_ff   <= c_in;
      sq_ff   <= sq_in;
      c_ff    <= c2_ff;
      cube_ff <= cube_in;
   end

   always_comb begin
      c3  = $signed({c_ff[OUT_W-1], c_ff, 1'b0}) + $signed({{2{c_ff[OUT_W-1]}}, c_ff});
      num = $signed({c3, 30'd0}) - cube_ff + 49'sh0_4000_0000;
      y_w = num[48:31];
      if (y_w > 18'sd32767) begin
         clip_out = 16'sh7fff;
      end else if (y_w < -18'sd32768) begin
         clip_out = -16'sh8000;
      end else begin
         clip_out = y_w[SAMPLE_W-1:0];
      end
   end

endmodule

>>> src/feedback_delay_soft_clip_unit.sv
// ----------------------------------------------------------------------------
// feedback_delay_soft_clip_unit
// Feedback echo delay: gliding delay length, linear tap interpolation,
// soft-clipped feedback written back into a circular delay memory.
// ----------------------------------------------------------------------------
// Steps: glide, S = 13 - clog2(DELAY_DEPTH) remainder steps (S = 0 above
//   4096 entries), address, tap reads, interpolate, sum, soft clip, write.
//   A new beat is taken only after the previous write; the write waits
//   while rsp_stall holds the prior result. The two tap reads share the
//   read port. Reset: clears the delay memory; req_stall is high until
//   then. Target register may be written at any time while idle.
// ----------------------------------------------------------------------------
module feedback_delay_soft_clip_unit
   import fdsc_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sample_type          req_in_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wide_sample_type     rsp_out_sample,
   input  logic                csr_write_enable,
   input  logic [TARGET_W-1:0] csr_write_data
);

   localparam int AW        = $clog2(DELAY_DEPTH);
   localparam int MOD_STEPS = (AW <= TARGET_W) ? (TARGET_W - AW + 1) : 0;
   localparam int K_INIT    = (MOD_STEPS > 0) ? (MOD_STEPS - 1) : 0;
   localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int CMP_W     = TARGET_W + 1;
   localparam int SUM_W     = ((AW > TARGET_W) ? AW : TARGET_W) + 1;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_GLIDE  = 4'd2;
   localparam logic [3:0] ST_MOD    = 4'd3;
   localparam logic [3:0] ST_ADDR   = 4'd4;
   localparam logic [3:0] ST_RDA    = 4'd5;
   localparam logic [3:0] ST_RDB    = 4'd6;
   localparam logic [3:0] ST_INTERP = 4'd7;
   localparam logic [3:0] ST_SUM    = 4'd8;
   localparam logic [3:0] ST_CLIP1  = 4'd9;
   localparam logic [3:0] ST_CLIP2  = 4'd10;
   localparam logic [3:0] ST_WRITE  = 4'd11;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

   // control
   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [SMOOTH_W-1:0] smoothed_ff, smoothed_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // payload
   sample_type          x_ff, x_in;
   logic signed [SMOOTH_W:0] diff_ff, diff_in;
   logic [TARGET_W-1:0] rem_ff, rem_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [AW-1:0]       pa_ff, pa_in;
   logic [AW-1:0]       pb_ff, pb_in;
   sample_type          a_ff, a_in;
   logic signed [41:0]  prod_ff, prod_in;
   wide_sample_type     sum_ff, sum_in;
   wide_sample_type     out_ff, out_in;

   // memory and clip
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   sample_type          mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   sample_type          mem_rd_data;
   sample_type          clip_y;

   // datapath temporaries
   logic signed [15:0]  step;
   logic [CMP_W-1:0]    div_step;
   logic [CMP_W-1:0]    rem_ext;
   logic [SUM_W-1:0]    pa_sum;
   logic signed [OUT_W-1:0] ab_diff;
   logic signed [41:0]  rnd;
   logic signed [17:0]  tap;
   logic signed [17:0]  sum_w;
   logic                out_busy;

   fdsc_store #(
      .DEPTH (DELAY_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fdsc_soft_clip u_clip (
      .clock    (clock),
      .sum_in   (sum_ff),
      .clip_out (clip_y)
   );

   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      smoothed_in  = smoothed_ff;
      target_in    = csr_write_enable ? csr_write_data : target_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      x_in         = x_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      a_in         = a_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      out_in       = out_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = wp_ff;
      mem_wr_data  = clip_y;
      mem_rd_addr  = (state_ff == ST_RDB) ? pb_ff : pa_ff;

      step     = diff_ff[SMOOTH_W:GLIDE_SHIFT];
      div_step = CMP_W'(DELAY_DEPTH) << k_ff;
      rem_ext  = {1'b0, rem_ff};
      pa_sum   = SUM_W'(wp_ff) + SUM_W'(rem_ff);
      ab_diff  = $signed({mem_rd_data[SAMPLE_W-1], mem_rd_data})
               - $signed({a_ff[SAMPLE_W-1], a_ff});
      rnd      = prod_ff + 42'sh0_0080_0000;
      tap      = $signed({{2{a_ff[SAMPLE_W-1]}}, a_ff}) + $signed(rnd[41:24]);
      sum_w    = tap + $signed({{2{x_ff[SAMPLE_W-1]}}, x_ff});

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_in_sample;
               diff_in  = $signed({1'b0, target_ff, {FRAC_W{1'b0}}})
                        - $signed({1'b0, smoothed_ff});
               state_in = ST_GLIDE;
            end
         end
         ST_GLIDE: begin
            smoothed_in = smoothed_ff + {{(SMOOTH_W-16){step[15]}}, step};
            rem_in      = smoothed_in[SMOOTH_W-1:FRAC_W];
            k_in        = KW'(K_INIT);
            state_in    = (MOD_STEPS > 0) ? ST_MOD : ST_ADDR;
         end
         ST_MOD: begin
            if (rem_ext >= div_step) begin
               rem_in = TARGET_W'(rem_ext - div_step);
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (pa_sum >= SUM_W'(DELAY_DEPTH)) begin
               pa_in = AW'(pa_sum - SUM_W'(DELAY_DEPTH));
            end else begin
               pa_in = AW'(pa_sum);
            end
            state_in = ST_RDA;
         end
         ST_RDA: begin
            pb_in    = (pa_ff == LAST_ADDR) ? '0 : pa_ff + 1'b1;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            a_in     = mem_rd_data;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            prod_in  = ab_diff * $signed({1'b0, smoothed_ff[FRAC_W-1:0]});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sum_w[OUT_W-1:0];
            state_in = ST_CLIP1;
         end
         ST_CLIP1: begin
            state_in = ST_CLIP2;
         end
         ST_CLIP2: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!out_busy) begin
               mem_wr_en    = 1'b1;
               out_in       = sum_ff;
               rsp_valid_in = 1'b1;
               wp_in        = (wp_ff == '0) ? LAST_ADDR : wp_ff - 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         smoothed_ff  <= '0;
         target_ff    <= TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         smoothed_ff  <= smoothed_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      out_ff  <= out_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_ff;

   // tap and write positions stay inside the delay memory
   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDA) |-> (pa_ff <= LAST_ADDR))
      else $error("tap position beyond delay depth");

   a_wp_in_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= LAST_ADDR)
      else $error("write position beyond delay depth");

   // glide never overshoots upward: new length stays at or below the old length or the target
   a_glide_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GLIDE) |=>
         (smoothed_ff <= $past(smoothed_ff)) ||
         (smoothed_ff <= {target_ff, {FRAC_W{1'b0}}}))
      else $error("delay glide overshoot");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !out_busy) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finished sample not presented");

endmodule
